// ----- rtl/core/tbdg_pkg.sv -----
package tbdg_pkg;

  // Fixed sizes of the block.
  localparam int CORES     = 64;
  localparam int CORE_W    = 6;
  localparam int FREQ_W    = 13;
  localparam int TEMP_W    = 12;
  localparam int STEP_W    = 12;
  localparam int DELTA_W   = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  // Band widths used by the suppression test.
  localparam int UNCERTAINTY_BAND = 8;
  localparam int SUPPRESS_BAND    = 16;

  // Opcodes.
  localparam logic OP_PROPOSE = 1'b0;
  localparam logic OP_VERIFY  = 1'b1;

  // Direction codes kept per core.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_GOAL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CRITICAL = 3'd7;

  // Register reset values.
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ      = 13'd1000;
  localparam logic [FREQ_W-1:0] RST_MAX_FREQ      = 13'd4000;
  localparam logic [STEP_W-1:0] RST_COARSE_STEP   = 12'd500;
  localparam logic [STEP_W-1:0] RST_FINE_FLOOR    = 12'd25;
  localparam logic [TEMP_W-1:0] RST_TEMP_LOW      = 12'd1040;
  localparam logic [TEMP_W-1:0] RST_TEMP_GOAL     = 12'd1120;
  localparam logic [TEMP_W-1:0] RST_TEMP_HIGH     = 12'd1200;
  localparam logic [TEMP_W-1:0] RST_TEMP_CRITICAL = 12'd1280;

  typedef struct packed {
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] max_freq;
    logic [STEP_W-1:0] coarse_step;
    logic [STEP_W-1:0] fine_floor;
    logic [TEMP_W-1:0] temp_low;
    logic [TEMP_W-1:0] temp_goal;
    logic [TEMP_W-1:0] temp_high;
    logic [TEMP_W-1:0] temp_critical;
  } cfg_t;

  // One request as it travels through the pipeline.
  typedef struct packed {
    logic                      opcode;
    logic [CORE_W-1:0]         core;
    logic [TEMP_W-1:0]         measured_temp;
    logic [FREQ_W-1:0]         old_freq;
    logic                      active;
    logic signed [DELTA_W-1:0] predicted_delta;
  } item_t;

  // Per-core state entry held in the state memory.
  typedef struct packed {
    logic [FREQ_W-1:0]         candidate;
    logic signed [DELTA_W-1:0] prev_delta;
    logic [1:0]                last_dir;
    logic [FREQ_W-1:0]         fine_step;
  } entry_t;

  localparam entry_t RST_ENTRY = '{
    candidate:  '0,
    prev_delta: '0,
    last_dir:   DIR_NONE,
    fine_step:  {1'b0, RST_COARSE_STEP}
  };

endpackage

// ----- rtl/core/tbdg_cfg_regs.sv -----
module tbdg_cfg_regs
  import tbdg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register file with decode on the write index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_freq      <= RST_MIN_FREQ;
      cfg_r.max_freq      <= RST_MAX_FREQ;
      cfg_r.coarse_step   <= RST_COARSE_STEP;
      cfg_r.fine_floor    <= RST_FINE_FLOOR;
      cfg_r.temp_low      <= RST_TEMP_LOW;
      cfg_r.temp_goal     <= RST_TEMP_GOAL;
      cfg_r.temp_high     <= RST_TEMP_HIGH;
      cfg_r.temp_critical <= RST_TEMP_CRITICAL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_FREQ:      cfg_r.min_freq      <= cfg_data;
        REG_MAX_FREQ:      cfg_r.max_freq      <= cfg_data;
        REG_COARSE_STEP:   cfg_r.coarse_step   <= cfg_data[STEP_W-1:0];
        REG_FINE_FLOOR:    cfg_r.fine_floor    <= cfg_data[STEP_W-1:0];
        REG_TEMP_LOW:      cfg_r.temp_low      <= cfg_data[TEMP_W-1:0];
        REG_TEMP_GOAL:     cfg_r.temp_goal     <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH:     cfg_r.temp_high     <= cfg_data[TEMP_W-1:0];
        REG_TEMP_CRITICAL: cfg_r.temp_critical <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/tbdg_state_mem.sv -----
module tbdg_state_mem
  import tbdg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Read port, issued when a request is accepted.
  input  logic              rd_en,
  input  logic [CORE_W-1:0] rd_addr,
  // Address of the request now using the read data.
  input  logic [CORE_W-1:0] use_addr,
  output entry_t            rd_entry,
  // Write-back port.
  input  logic              wr_en,
  input  logic [CORE_W-1:0] wr_addr,
  input  entry_t            wr_entry
);

  entry_t             mem_r [CORES];
  logic [CORES-1:0]   vld_r;
  entry_t             rd_data_r;
  logic               rd_vld_r;
  logic               fwd_vld_r;
  logic [CORE_W-1:0]  fwd_addr_r;
  entry_t             fwd_data_r;

  // Synchronous memory: one read and one write per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Written flags per entry; an unwritten entry reads as its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // Last write is kept to cover a read issued in the same cycle as the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else if (wr_en) begin
      fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_entry;
    end
  end

  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == use_addr)) begin
      rd_entry = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_entry = rd_data_r;
    end else begin
      rd_entry = RST_ENTRY;
    end
  end

endmodule

// ----- rtl/core/tbdg_update.sv -----
module tbdg_update
  import tbdg_pkg::*;
(
  input  cfg_t              cfg,
  input  item_t             item,
  input  entry_t            cur,
  output entry_t            nxt,
  output logic [FREQ_W-1:0] freq,
  output logic              overridden
);

  logic signed [14:0] eff;
  logic signed [14:0] effv;
  logic signed [14:0] pd_s;
  logic signed [14:0] oldf_s;
  logic signed [14:0] fmin_s;
  logic signed [14:0] fmax_s;
  logic signed [14:0] crit_s;
  logic signed [14:0] high_s;
  logic signed [14:0] low_s;
  logic signed [14:0] goal_s;
  logic signed [14:0] goal_diff;
  logic signed [14:0] nf_down;
  logic [13:0]        nf_up;
  logic signed [14:0] nf_fine;
  logic signed [14:0] nf_lo;
  logic [1:0]         dir;
  logic [FREQ_W-1:0]  half;
  logic [FREQ_W-1:0]  step_nxt;
  logic               suppress;
  logic               go_down;
  logic [FREQ_W-1:0]  coarse13;

  // Widened operands for signed compares.
  assign oldf_s   = $signed({2'b00, item.old_freq});
  assign fmin_s   = $signed({2'b00, cfg.min_freq});
  assign fmax_s   = $signed({2'b00, cfg.max_freq});
  assign crit_s   = $signed({3'b000, cfg.temp_critical});
  assign high_s   = $signed({3'b000, cfg.temp_high});
  assign low_s    = $signed({3'b000, cfg.temp_low});
  assign goal_s   = $signed({3'b000, cfg.temp_goal});
  assign coarse13 = {1'b0, cfg.coarse_step};
  assign pd_s     = $signed({{3{cur.prev_delta[DELTA_W-1]}}, cur.prev_delta});

  // Effective temperatures: stored delta for propose, new delta for verify.
  assign eff  = $signed({3'b000, item.measured_temp}) + pd_s;
  assign effv = $signed({3'b000, item.measured_temp})
              + $signed({{3{item.predicted_delta[DELTA_W-1]}}, item.predicted_delta});
  assign goal_diff = eff - goal_s;

  // Hold when close to the goal with a small delta, or when the step is spent.
  assign suppress =
      ((pd_s > -15'(UNCERTAINTY_BAND)) && (pd_s < 15'(UNCERTAINTY_BAND)) &&
       (goal_diff > -15'(SUPPRESS_BAND)) && (goal_diff < 15'(SUPPRESS_BAND))) ||
      (cur.fine_step < {1'b0, cfg.fine_floor});

  // Bisection: halve the step on a change of direction.
  assign go_down = eff > goal_s;
  assign dir     = go_down ? DIR_DOWN : DIR_UP;
  assign half    = cur.fine_step >> 1;
  always_comb begin
    if ((cur.last_dir != DIR_NONE) && (dir != cur.last_dir)) begin
      step_nxt = (half > {1'b0, cfg.fine_floor}) ? half : {1'b0, cfg.fine_floor};
    end else begin
      step_nxt = cur.fine_step;
    end
  end

  assign nf_fine = go_down ? (oldf_s - $signed({2'b00, step_nxt}))
                           : (oldf_s + $signed({2'b00, step_nxt}));
  assign nf_lo   = (nf_fine < fmin_s) ? fmin_s : nf_fine;

  // Coarse steps for the high and low bands.
  assign nf_down = oldf_s - $signed({3'b000, cfg.coarse_step});
  assign nf_up   = {1'b0, item.old_freq} + {2'b00, cfg.coarse_step};

  always_comb begin
    nxt        = cur;
    freq       = cur.candidate;
    overridden = 1'b0;
    if (item.opcode == OP_PROPOSE) begin
      if (!item.active) begin
        freq = cfg.max_freq;
        nxt.fine_step = coarse13;
        nxt.last_dir  = DIR_NONE;
      end else if (eff > crit_s) begin
        freq = cfg.min_freq;
        nxt.fine_step = coarse13;
        nxt.last_dir  = DIR_NONE;
      end else if (eff > high_s) begin
        freq = (nf_down > fmin_s) ? nf_down[FREQ_W-1:0] : cfg.min_freq;
        nxt.fine_step = coarse13;
        nxt.last_dir  = DIR_NONE;
      end else if (eff < low_s) begin
        freq = (nf_up < {1'b0, cfg.max_freq}) ? nf_up[FREQ_W-1:0] : cfg.max_freq;
        nxt.fine_step = coarse13;
        nxt.last_dir  = DIR_NONE;
      end else if (suppress) begin
        freq = item.old_freq;
      end else begin
        nxt.fine_step = step_nxt;
        nxt.last_dir  = dir;
        freq = (nf_lo > fmax_s) ? cfg.max_freq : nf_lo[FREQ_W-1:0];
      end
      nxt.candidate = freq;
    end else begin
      // Verify stores the new delta and may override the candidate.
      nxt.prev_delta = item.predicted_delta;
      if (item.active) begin
        if (effv > crit_s) begin
          freq = cfg.min_freq;
          nxt.fine_step = coarse13;
          nxt.last_dir  = DIR_NONE;
        end else if ((effv > high_s) && (cur.candidate > item.old_freq)) begin
          freq = item.old_freq;
          nxt.fine_step = coarse13;
          nxt.last_dir  = DIR_NONE;
        end
      end
      overridden = freq != cur.candidate;
    end
  end

endmodule

// ----- rtl/core/thermal_band_dvfs_governor_top.sv -----
// Path: memory read and request register on acceptance, then update and output register.
// Throughput: one request per cycle unless out_tready stalls the output, set by the
// single read-modify-write of the per-core state memory; back-to-back requests to one
// core use write forwarding.
// Reset: synchronous active-low rst_n restores the register defaults, empties the
// pipeline and clears the per-core written flags; no memory clearing pass.
module thermal_band_dvfs_governor_top
  import tbdg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [5:0] core, [17:6] measured_temp, [30:18] old_freq, [31] active,
  // [43:32] predicted_delta, [47:44] zero
  input  logic [47:0]          in_tdata,
  // [0] opcode
  input  logic                 in_tuser,
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [5:0] out_core, [18:6] freq, [23:19] zero
  output logic [23:0]          out_tdata,
  // [0] opcode, [1] overridden
  output logic [1:0]           out_tuser
);

  cfg_t              cfg;
  item_t             in_item;
  item_t             s1_item_r;
  logic              s1_vld_r;
  logic              s1_adv;
  logic              in_acc;
  entry_t            cur_entry;
  entry_t            nxt_entry;
  logic [FREQ_W-1:0] res_freq;
  logic              res_ovr;
  logic              out_vld_r;
  logic [23:0]       out_tdata_r;
  logic [1:0]        out_tuser_r;

  tbdg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the request.
  assign in_item.opcode          = in_tuser;
  assign in_item.core            = in_tdata[5:0];
  assign in_item.measured_temp   = in_tdata[17:6];
  assign in_item.old_freq        = in_tdata[30:18];
  assign in_item.active          = in_tdata[31];
  assign in_item.predicted_delta = $signed(in_tdata[43:32]);

  // Pipeline handshake: the update stage moves when the output slot frees.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  tbdg_state_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (in_item.core),
    .use_addr (s1_item_r.core),
    .rd_entry (cur_entry),
    .wr_en    (s1_adv),
    .wr_addr  (s1_item_r.core),
    .wr_entry (nxt_entry)
  );

  tbdg_update u_upd (
    .cfg        (cfg),
    .item       (s1_item_r),
    .cur        (cur_entry),
    .nxt        (nxt_entry),
    .freq       (res_freq),
    .overridden (res_ovr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= {5'b00000, res_freq, s1_item_r.core};
      out_tuser_r <= {res_ovr, s1_item_r.opcode};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
